FILE: rtl/core/tes_pkg.sv
// shared codes and default sizes for the timed event scheduler
package tes_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TIME_BITS   = 32;
  localparam int DEF_ID_BITS     = 16;

  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REWIND  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

  localparam logic KIND_FIRED  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_HOLD   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
  localparam logic [OP_W-1:0] OP_ROTATE = 3'd2;
  localparam logic [OP_W-1:0] OP_REWIND = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

endpackage

FILE: rtl/core/tes_cell.sv
// one slot of the sorted event chain
module tes_cell import tes_pkg::*; #(
  parameter int TIME_BITS = DEF_TIME_BITS,
  parameter int ID_BITS   = DEF_ID_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [OP_W-1:0]      op,
  input  logic [TIME_BITS-1:0] tv,
  input  logic [ID_BITS-1:0]   id,
  input  logic [TIME_BITS-1:0] clock_now,
  input  logic                 prev_after,
  input  logic                 left_valid,
  input  logic                 left_pending,
  input  logic [TIME_BITS-1:0] left_stamp,
  input  logic [ID_BITS-1:0]   left_id,
  input  logic                 right_valid,
  input  logic                 right_pending,
  input  logic [TIME_BITS-1:0] right_stamp,
  input  logic [ID_BITS-1:0]   right_id,
  output logic                 valid,
  output logic                 pending,
  output logic [TIME_BITS-1:0] stamp,
  output logic [ID_BITS-1:0]   slot_id,
  output logic                 after,
  output logic                 due
);

  assign after = valid && (stamp <= tv);
  assign due   = valid && pending && (stamp <= clock_now);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      pending <= 1'b0;
    end else begin
      unique case (op)
        OP_ADD: begin
          if (!after) begin
            if (prev_after) begin
              valid   <= 1'b1;
              pending <= 1'b0;
            end else begin
              valid   <= left_valid;
              pending <= left_pending;
            end
          end
        end
        OP_ROTATE: begin
          valid   <= right_valid;
          pending <= right_pending;
        end
        OP_REWIND: pending <= valid && (stamp >= tv);
        OP_CLEAR: begin
          valid   <= 1'b0;
          pending <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_ADD: begin
        if (!after) begin
          if (prev_after) begin
            stamp   <= tv;
            slot_id <= id;
          end else begin
            stamp   <= left_stamp;
            slot_id <= left_id;
          end
        end
      end
      OP_ROTATE: begin
        stamp   <= right_stamp;
        slot_id <= right_id;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/timed_event_scheduler.sv
// timed event scheduler: sorted chain of event slots with a millisecond clock
//
// input beats (s_*): s_tuser selects add, advance, rewind or clear; s_tdata
// carries the time value and the event id. output beats (m_*): one per fired
// event, or one when an add finds the store full (m_tuser high); m_tlast marks
// the final beat caused by an input beat.
// an add into a full store leaves its reject beat in the output register.
// advance first updates the clock, then the chain rotates by one slot per
// cycle past the head (while no due event there waits for the output
// register), which fires the event there if it is pending and due. a full
// rotation restores the order.
// the block takes a new input beat only when idle with the output register
// empty. a due event at the head waits there while the output register still
// holds a beat that m_tready has not taken, so a stalled receiver stretches
// the scan.
// reset clears the clock and all slot valid and pending marks; the slot
// payload needs no reset. ready is low during reset.
module timed_event_scheduler import tes_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TIME_BITS   = DEF_TIME_BITS,
  parameter int ID_BITS     = DEF_ID_BITS,
  localparam int DATA_W     = ((TIME_BITS + ID_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // time_value, event_id, zero pad
  input  logic [MODE_W-1:0] s_tuser,   // mode
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // fired_id, fired_time, zero pad
  output logic              m_tuser,   // kind
  output logic              m_tlast
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                 state;
  logic [CNT_W-1:0]     cnt;
  logic [TIME_BITS-1:0] clock_now;

  logic [TIME_BITS-1:0] in_time;
  logic [ID_BITS-1:0]   in_id;
  logic                 accept;

  logic                 out_valid;
  logic                 out_kind;
  logic                 out_last;
  logic [TIME_BITS-1:0] out_time;
  logic [ID_BITS-1:0]   out_id;
  logic                 out_free;

  logic [OP_W-1:0]      op;
  logic                 step;
  logic                 hit;
  logic [TIME_BITS:0]   sum;

  logic [QUEUE_DEPTH-1:0] c_valid;
  logic [QUEUE_DEPTH-1:0] c_pending;
  logic [QUEUE_DEPTH-1:0] c_after;
  logic [QUEUE_DEPTH-1:0] c_due;
  logic [TIME_BITS-1:0]   c_stamp [QUEUE_DEPTH];
  logic [ID_BITS-1:0]     c_id    [QUEUE_DEPTH];

  assign in_time  = s_tdata[TIME_BITS-1:0];
  assign in_id    = s_tdata[TIME_BITS +: ID_BITS];
  assign s_tready = !rst && (state == ST_IDLE) && !out_valid;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign hit      = c_due[0];
  assign step     = (state == ST_SCAN) && (!hit || out_free);
  assign sum      = {1'b0, clock_now} + {1'b0, in_time};

  always_comb begin
    op = OP_HOLD;
    if (accept) begin
      unique case (s_tuser)
        MODE_ADD:     op = c_valid[QUEUE_DEPTH-1] ? OP_HOLD : OP_ADD;
        MODE_REWIND:  op = OP_REWIND;
        MODE_CLEAR:   op = OP_CLEAR;
        default:      op = OP_HOLD;
      endcase
    end else if (step) begin
      op = OP_ROTATE;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 l_valid, l_pending, r_valid, r_pending, p_after;
    logic [TIME_BITS-1:0] l_stamp, r_stamp;
    logic [ID_BITS-1:0]   l_id, r_id;

    if (i == 0) begin : g_head
      assign p_after   = 1'b1;
      assign l_valid   = c_valid[QUEUE_DEPTH-1];
      assign l_pending = c_pending[QUEUE_DEPTH-1];
      assign l_stamp   = c_stamp[QUEUE_DEPTH-1];
      assign l_id      = c_id[QUEUE_DEPTH-1];
    end else begin : g_body
      assign p_after   = c_after[i-1];
      assign l_valid   = c_valid[i-1];
      assign l_pending = c_pending[i-1];
      assign l_stamp   = c_stamp[i-1];
      assign l_id      = c_id[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      // head wraps round to the tail, its mark cleared once fired
      assign r_valid   = c_valid[0];
      assign r_pending = c_pending[0] && !hit;
      assign r_stamp   = c_stamp[0];
      assign r_id      = c_id[0];
    end else begin : g_mid
      assign r_valid   = c_valid[i+1];
      assign r_pending = c_pending[i+1];
      assign r_stamp   = c_stamp[i+1];
      assign r_id      = c_id[i+1];
    end

    tes_cell #(
      .TIME_BITS(TIME_BITS),
      .ID_BITS  (ID_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .op           (op),
      .tv           (in_time),
      .id           (in_id),
      .clock_now    (clock_now),
      .prev_after   (p_after),
      .left_valid   (l_valid),
      .left_pending (l_pending),
      .left_stamp   (l_stamp),
      .left_id      (l_id),
      .right_valid  (r_valid),
      .right_pending(r_pending),
      .right_stamp  (r_stamp),
      .right_id     (r_id),
      .valid        (c_valid[i]),
      .pending      (c_pending[i]),
      .stamp        (c_stamp[i]),
      .slot_id      (c_id[i]),
      .after        (c_after[i]),
      .due          (c_due[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      clock_now <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && s_tuser == MODE_ADVANCE) begin
            clock_now <= sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
            cnt       <= '0;
            state     <= ST_SCAN;
          end else if (accept && s_tuser == MODE_REWIND) begin
            clock_now <= in_time;
          end
        end
        ST_SCAN: begin
          if (step) begin
            cnt <= cnt + 1'b1;
            if (cnt == CNT_W'(QUEUE_DEPTH - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && s_tuser == MODE_ADD && c_valid[QUEUE_DEPTH-1]) begin
      out_valid <= 1'b1;
    end else if (step && hit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tuser == MODE_ADD && c_valid[QUEUE_DEPTH-1]) begin
      out_kind <= KIND_REJECT;
      out_id   <= in_id;
      out_time <= in_time;
      out_last <= 1'b1;
    end else if (step && hit) begin
      out_kind <= KIND_FIRED;
      out_id   <= c_id[0];
      out_time <= c_stamp[0];
      out_last <= (c_due[QUEUE_DEPTH-1:1] == '0);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = DATA_W'({out_time, out_id});

  a_compact: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> ((c_valid >> 1) & ~c_valid) == '0)
    else $error("store not compact while idle");

  a_reject_only_full: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == MODE_ADD && !c_valid[QUEUE_DEPTH-1]) |=> !out_valid)
    else $error("result raised by an add into a store with room");

  a_fired_due: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_FIRED) |-> out_time <= clock_now)
    else $error("fired event not yet due");

  a_no_accept_scan: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> op != OP_ADD && op != OP_REWIND && op != OP_CLEAR)
    else $error("chain command issued during a scan");

endmodule
